### rtl/core/array_deque_with_compaction_macros.svh
// ----------------------------------------------------------------------------
// array_deque_with_compaction_macros.svh
// Assertion macros used by the deque RTL.
// ----------------------------------------------------------------------------
`ifndef ARRAY_DEQUE_WITH_COMPACTION_MACROS_SVH
`define ARRAY_DEQUE_WITH_COMPACTION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ADQC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed");

// Next-cycle implication, checked outside reset.
`define ADQC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

### rtl/core/adqc_pkg.sv
// ----------------------------------------------------------------------------
// adqc_pkg
// Types and codes for the compacting array deque.
// ----------------------------------------------------------------------------
package adqc_pkg;

   // Widest slot index any configuration can need (64 slots).
   localparam int MAX_INDEX_W = 6;

   typedef enum logic [1:0] {
      KIND_INSERT_REAR  = 2'd0,
      KIND_REMOVE_FRONT = 2'd1,
      KIND_INSERT_FRONT = 2'd2,
      KIND_REMOVE_REAR  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] item_value;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] removed_value;
      logic [1:0]         status;
      logic [3:0]         occupancy;
   } rsp_word_type;

   // Broadcast to every cell of the slot row.
   typedef struct packed {
      logic                   load;
      logic [MAX_INDEX_W-1:0] load_index;
      logic                   from_above;
      logic                   from_below;
   } cell_ctrl_type;

endpackage

### rtl/core/adqc_cell.sv
// ----------------------------------------------------------------------------
// adqc_cell
// One slot of the deque row: loads a new word or takes its neighbor's slot.
// ----------------------------------------------------------------------------
module adqc_cell
   import adqc_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [DATA_WIDTH-1:0] below_data,
   input  logic [DATA_WIDTH-1:0] above_data,
   output logic [DATA_WIDTH-1:0] slot_data
);

   logic [DATA_WIDTH-1:0] slot_ff;
   logic [DATA_WIDTH-1:0] slot_in;
   logic                  hit;

   assign hit = ctrl.load && (ctrl.load_index == MAX_INDEX_W'(CELL_INDEX));

   // Pick the load, then a shift from either neighbor, else hold
   always_comb begin
      if (hit) begin
         slot_in = wr_data;
      end else if (ctrl.from_above) begin
         slot_in = above_data;
      end else if (ctrl.from_below) begin
         slot_in = below_data;
      end else begin
         slot_in = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot_data = slot_ff;

endmodule

### rtl/core/array_deque_with_compaction.sv
// ----------------------------------------------------------------------------
// array_deque_with_compaction
// Fixed-size deque in a row of slot cells with front/rear indices; the row
// shifts one slot to make room when an insert hits an array end.
//
//   channel | ports                         | word
//   --------+-------------------------------+---------------------
//   request | req_valid, req_stall, req_data | req_type, item_value
//   result  | rsp_valid, rsp_stall, rsp_data | removed_value, status,
//           |                               | occupancy
//
// One request per cycle while not stalled; the whole slot row updates (load or
// shift) in the accepting cycle and the result appears from the output register
// in the next cycle. A request is stalled only while a held result waits on rsp_stall.
// Synchronous reset empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
`include "array_deque_with_compaction_macros.svh"

module array_deque_with_compaction
   import adqc_pkg::*;
#(
   parameter int DEPTH      = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [IW-1:0]         head_ff, head_in;
   logic [IW-1:0]         tail_ff, tail_in;
   logic                  empty_ff, empty_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_data_ff, rsp_data_in;

   logic                  accept;
   req_kind_type          req_kind;
   cell_ctrl_type         ctrl;
   logic [63:0]           item_wide;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] slot_row [DEPTH];
   logic [IW-1:0]         rd_index;
   logic [63:0]           rd_wide;
   logic [CW-1:0]         count;
   logic                  at_top;
   logic                  at_bottom;
   logic                  full_insert;
   logic                  rsp_full;

   // Take a word unless a finished result is still held
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign req_kind  = req_kind_type'(req_data.req_type);

   assign item_wide = {32'd0, req_data.item_value};
   assign wr_data   = item_wide[DATA_WIDTH-1:0];

   assign at_top    = (tail_ff == IW'(DEPTH - 1));
   assign at_bottom = (head_ff == '0);

   // Flag an insert that meets a full row
   assign full_insert = accept && !empty_ff && at_top && at_bottom &&
                        ((req_kind == KIND_INSERT_REAR) || (req_kind == KIND_INSERT_FRONT));
   assign rsp_full    = (rsp_data_ff.status == STATUS_FULL);

   // Read the end that a removal takes from
   assign rd_index = (req_kind == KIND_REMOVE_FRONT) ? head_ff : tail_ff;
   assign rd_wide  = 64'(slot_row[rd_index]);

   // Slot row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] below;
      logic [DATA_WIDTH-1:0] above;
      if (i == 0) begin : g_lo
         assign below = '0;
      end else begin : g_lo
         assign below = slot_row[i-1];
      end
      if (i == DEPTH - 1) begin : g_hi
         assign above = '0;
      end else begin : g_hi
         assign above = slot_row[i+1];
      end
      adqc_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .wr_data    (wr_data),
         .below_data (below),
         .above_data (above),
         .slot_data  (slot_row[i])
      );
   end

   // Decode the request into index updates, cell commands and a result
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      empty_in = empty_ff;
      ctrl     = '0;
      rsp_data_in.removed_value = '0;
      rsp_data_in.status        = STATUS_DONE;
      case (req_kind)
         KIND_INSERT_REAR, KIND_INSERT_FRONT: begin
            if (empty_ff) begin
               head_in         = '0;
               tail_in         = '0;
               empty_in        = 1'b0;
               ctrl.load       = 1'b1;
               ctrl.load_index = '0;
            end else if (at_top && at_bottom) begin
               rsp_data_in.status = STATUS_FULL;
            end else if (req_kind == KIND_INSERT_REAR) begin
               if (at_top) begin
                  // compact downward, new word lands in the top slot
                  ctrl.from_above = 1'b1;
                  ctrl.load       = 1'b1;
                  ctrl.load_index = MAX_INDEX_W'(DEPTH - 1);
                  head_in         = head_ff - IW'(1);
               end else begin
                  tail_in         = tail_ff + IW'(1);
                  ctrl.load       = 1'b1;
                  ctrl.load_index = MAX_INDEX_W'(tail_in);
               end
            end else begin
               if (at_bottom) begin
                  // compact upward, new word lands in slot zero
                  ctrl.from_below = 1'b1;
                  ctrl.load       = 1'b1;
                  ctrl.load_index = '0;
                  tail_in         = tail_ff + IW'(1);
               end else begin
                  head_in         = head_ff - IW'(1);
                  ctrl.load       = 1'b1;
                  ctrl.load_index = MAX_INDEX_W'(head_in);
               end
            end
         end
         KIND_REMOVE_FRONT, KIND_REMOVE_REAR: begin
            if (empty_ff) begin
               rsp_data_in.status = STATUS_EMPTY;
            end else begin
               rsp_data_in.removed_value = rd_wide[31:0];
               if (head_ff == tail_ff) begin
                  empty_in = 1'b1;
                  head_in  = '0;
                  tail_in  = '0;
               end else if (req_kind == KIND_REMOVE_FRONT) begin
                  head_in = head_ff + IW'(1);
               end else begin
                  tail_in = tail_ff - IW'(1);
               end
            end
         end
         default: begin
            rsp_data_in.status = STATUS_DONE;
         end
      endcase
      // no cell moves without an accepted word
      if (!accept) begin
         ctrl = '0;
      end
      count = empty_in ? '0 : (CW'(tail_in) - CW'(head_in) + CW'(1));
      rsp_data_in.occupancy = 4'(count);
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   // Index and empty state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `ADQC_ASSERT_NOW(a_order, clock, reset, !empty_ff, head_ff <= tail_ff)
   `ADQC_ASSERT_NOW(a_empty_idx, clock, reset, empty_ff, (head_ff == '0) && (tail_ff == '0))
   `ADQC_ASSERT_NEXT(a_result, clock, reset, accept, rsp_valid_ff)
   `ADQC_ASSERT_NEXT(a_full, clock, reset, full_insert, rsp_full && $stable({head_ff, tail_ff}))

endmodule

### sim/array_deque_with_compaction_tb.sv
// ----------------------------------------------------------------------------
// array_deque_with_compaction_tb
// Self-checking bench for the compacting array deque. A scoreboard class keeps
// its own copy of the slot row and end indices, predicts the result word of
// every accepted request, and compares each result word field by field.
// The stimulus starts with a directed pass over underflow, overflow and both
// shift cases. It then runs random blocks, most biased toward filling or
// draining, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module array_deque_with_compaction_tb;
   import adqc_pkg::*;

   localparam int SLOT_COUNT     = 8;
   localparam int RANDOM_ITEMS   = 1150;
   localparam int BLOCK_ITEMS    = 50;
   localparam int MAX_WAIT       = 18;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 4;

   // Predict deque behavior and hold the result words still due
   class deque_scoreboard;
      logic [31:0]  slot_q [SLOT_COUNT];
      int unsigned  front_idx;
      int unsigned  rear_idx;
      bit           held_none;
      rsp_word_type due_q [$];
      int unsigned  error_count;

      function new();
         front_idx   = 0;
         rear_idx    = 0;
         held_none   = 1'b1;
         error_count = 0;
      endfunction

      function int pending();
         return due_q.size();
      endfunction

      // Apply one accepted request word and queue the result it produces
      function void note_request(req_word_type w);
         rsp_word_type r;
         req_kind_type kind;
         int           i;
         kind            = req_kind_type'(w.req_type);
         r               = '0;
         r.status        = STATUS_DONE;
         if ((kind == KIND_INSERT_REAR || kind == KIND_INSERT_FRONT) && held_none) begin
            // First entry always lands in slot 0
            front_idx = 0;
            rear_idx  = 0;
            slot_q[0] = w.item_value;
            held_none = 1'b0;
         end else begin
            case (kind)
               KIND_INSERT_REAR: begin
                  if (rear_idx == SLOT_COUNT - 1) begin
                     if (front_idx == 0) begin
                        r.status = STATUS_FULL;
                     end else begin
                        // Compact downward to free the top slot
                        for (i = front_idx; i <= rear_idx; i++)
                           slot_q[i-1] = slot_q[i];
                        front_idx--;
                        slot_q[rear_idx] = w.item_value;
                     end
                  end else begin
                     rear_idx++;
                     slot_q[rear_idx] = w.item_value;
                  end
               end
               KIND_INSERT_FRONT: begin
                  if (front_idx == 0) begin
                     if (rear_idx == SLOT_COUNT - 1) begin
                        r.status = STATUS_FULL;
                     end else begin
                        // Compact upward to free slot 0
                        for (i = rear_idx + 1; i > 0; i--)
                           slot_q[i] = slot_q[i-1];
                        rear_idx++;
                        slot_q[0] = w.item_value;
                     end
                  end else begin
                     front_idx--;
                     slot_q[front_idx] = w.item_value;
                  end
               end
               default: begin
                  if (held_none) begin
                     r.status = STATUS_EMPTY;
                  end else begin
                     r.removed_value = (kind == KIND_REMOVE_FRONT) ?
                                       slot_q[front_idx] : slot_q[rear_idx];
                     if (front_idx == rear_idx) begin
                        held_none = 1'b1;
                        front_idx = 0;
                        rear_idx  = 0;
                     end else if (kind == KIND_REMOVE_FRONT) begin
                        front_idx++;
                     end else begin
                        rear_idx--;
                     end
                  end
               end
            endcase
         end
         r.occupancy = held_none ? 4'd0 : 4'(rear_idx - front_idx + 1);
         due_q.push_back(r);
      endfunction

      // Compare one accepted result word with the oldest prediction
      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (due_q.size() == 0) begin
            $display("%0t: result word with none expected, got %h", $time, got);
            error_count++;
            return;
         end
         want = due_q.pop_front();
         if (got.removed_value !== want.removed_value) begin
            $display("%0t: removed_value expected %0d, got %0d",
                     $time, want.removed_value, got.removed_value);
            error_count++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            error_count++;
         end
         if (got.occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d, got %0d",
                     $time, want.occupancy, got.occupancy);
            error_count++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_data;

   deque_scoreboard sb = new();

   bit req_no_idle  = 1'b0;
   bit rsp_no_idle  = 1'b0;
   int stall_left   = 0;
   int idle_cycles  = 0;

   array_deque_with_compaction #(
      .DEPTH      (SLOT_COUNT),
      .DATA_WIDTH (32)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one request word from a falling edge and hold it until accepted
   task automatic send_request(input req_word_type w);
      int gap;
      gap = req_no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do
         @(posedge clock);
      while (!(req_valid === 1'b1 && req_stall === 1'b0));
      sb.note_request(w);
      @(negedge clock);
   endtask

   task automatic send_op(input req_kind_type kind, input logic [31:0] value);
      req_word_type w;
      w.req_type   = kind;
      w.item_value = value;
      send_request(w);
   endtask

   // Hold off the sender until every result word is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (sb.pending() != 0);
   endtask

   function automatic req_word_type random_word(input int unsigned insert_pct);
      req_word_type w;
      if ($urandom_range(0, 99) < insert_pct)
         w.req_type = $urandom_range(0, 1) ? KIND_INSERT_REAR : KIND_INSERT_FRONT;
      else
         w.req_type = $urandom_range(0, 1) ? KIND_REMOVE_FRONT : KIND_REMOVE_REAR;
      case ($urandom_range(0, 7))
         0:       w.item_value = 32'h8000_0000;
         1:       w.item_value = 32'h7fff_ffff;
         2:       w.item_value = '1;
         default: w.item_value = $urandom();
      endcase
      return w;
   endfunction

   // Accept result words, check them, and draw the next stall stretch
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            sb.check_result(rsp_data);
            stall_left = rsp_no_idle ? 0 : $urandom_range(0, MAX_WAIT);
         end
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: end the run when no word moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Main stimulus
   initial begin
      int          blk;
      int          n;
      int unsigned insert_pct;
      req_valid = 1'b0;
      req_data  = '0;
      reset     = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Underflow at both ends, then first insert and last removal
      send_op(KIND_REMOVE_FRONT, 32'h1234_5678);
      send_op(KIND_REMOVE_REAR, '1);
      send_op(KIND_INSERT_REAR, 32'h7fff_ffff);
      send_op(KIND_REMOVE_REAR, '0);
      send_op(KIND_INSERT_FRONT, 32'h8000_0000);
      // Fill to the top
      for (n = 0; n < SLOT_COUNT - 1; n++)
         send_op(KIND_INSERT_REAR, (n == 0) ? 32'hffff_ffff : (n == 1) ? 32'h0 : $urandom());
      // Overflow at both ends
      send_op(KIND_INSERT_REAR, $urandom());
      send_op(KIND_INSERT_FRONT, $urandom());
      // Open the front, then force a downward shift on a rear insert
      send_op(KIND_REMOVE_FRONT, $urandom());
      send_op(KIND_INSERT_REAR, 32'h5a5a_a5a5);
      // Open the rear, then force an upward shift on a front insert
      send_op(KIND_REMOVE_REAR, $urandom());
      send_op(KIND_INSERT_FRONT, 32'ha5a5_5a5a);
      send_op(KIND_REMOVE_FRONT, $urandom());
      send_op(KIND_REMOVE_REAR, $urandom());
      drain_results();

      // Random blocks, each with its own fill bias and idling mode
      for (blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
         req_no_idle = ($urandom_range(0, 2) == 0);
         rsp_no_idle = ($urandom_range(0, 2) == 0);
         case ($urandom_range(0, 3))
            0:       insert_pct = 15;
            1:       insert_pct = 85;
            2:       insert_pct = 65;
            default: insert_pct = 50;
         endcase
         for (n = 0; n < BLOCK_ITEMS; n++)
            send_request(random_word(insert_pct));
         if (blk == RANDOM_ITEMS / BLOCK_ITEMS / 2)
            drain_results();
      end

      // Wait out the last result words
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
